[sv/rwhp_pkg.sv]
`timescale 1ns / 1ps

package rwhp_pkg;

    // Width of the byte position; a stream longer than 2^POSITION_BITS - 1 bytes overflows.
    localparam int POSITION_BITS = 31;
    localparam int POS_W         = POSITION_BITS + 1;
    localparam int OFS_W         = 31;

    localparam logic [POS_W-1:0] POS_MAX   = {1'b0, {POSITION_BITS{1'b1}}};
    localparam logic [POS_W-1:0] POS_LIMIT = {1'b1, {POSITION_BITS{1'b0}}};
    localparam logic [POS_W-1:0] MIN_FILE_BYTES = POS_W'(44);
    localparam logic [POS_W-1:0] FILE_HDR_BYTES = POS_W'(12);

    // Chunk tags as they read little-endian from four bytes.
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [15:0] FMT_CODE_PCM = 16'd1;
    localparam logic [15:0] PCM_BITS     = 16'd16;
    localparam logic [31:0] FMT_MIN_LEN  = 32'd16;

    // Summary of the parser state after a byte is taken.
    typedef struct packed {
        logic [POS_W-1:0]         pos;
        logic                     hdr_good;
        logic                     fmt_found;
        logic                     pay_found;
        logic [15:0]              chan;
        logic [31:0]              rate;
        logic [15:0]              bits;
        logic [POSITION_BITS-1:0] pay_start;
        logic [31:0]              pay_size;
    } t_snap;

    // Expected byte of the file header at offsets 0 to 11.
    function automatic logic [7:0] file_tag_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0:    v = 8'h52;
            4'd1:    v = 8'h49;
            4'd2:    v = 8'h46;
            4'd3:    v = 8'h46;
            4'd8:    v = 8'h57;
            4'd9:    v = 8'h41;
            4'd10:   v = 8'h56;
            4'd11:   v = 8'h45;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    // Offsets 4 to 7 hold the file size, which is not checked.
    function automatic logic file_tag_care(input logic [3:0] idx);
        logic v;
        case (idx)
            4'd0, 4'd1, 4'd2, 4'd3, 4'd8, 4'd9, 4'd10, 4'd11: v = 1'b1;
            default: v = 1'b0;
        endcase
        return v;
    endfunction

endpackage

[sv/riff_wav_header_parser.sv]
`timescale 1ns / 1ps

// Channel | Handshake                  | Beat contents
// in      | i_in_valid / o_in_ready    | i_data_byte, i_last_byte
// out     | o_out_valid / i_out_ready  | o_valid_res, o_num_channels, o_sample_rate,
//         |                            | o_bits_per_sample, o_data_offset, o_data_length
//
// One byte is taken every cycle while o_in_ready is high; the parser state updates at the edge that takes the beat.
// That edge also loads a snapshot register for a last byte, and the result register loads
// from it once the result register is empty or its beat is taken, and then offers the result.
// Synchronous active-low reset clears the parser and both valid flags.
// Input stalls only while the snapshot and the result register are both full and the
// result beat is not taken.
module riff_wav_header_parser (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_last_byte,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic                     o_valid_res,
    output logic [15:0]              o_num_channels,
    output logic [31:0]              o_sample_rate,
    output logic [15:0]              o_bits_per_sample,
    output logic [rwhp_pkg::OFS_W-1:0] o_data_offset,
    output logic [rwhp_pkg::OFS_W-1:0] o_data_length
);
    import rwhp_pkg::*;

    logic             in_acc;
    logic             snp_adv;
    t_snap            snap_next;
    t_snap            r_snp;
    logic             r_snp_vld;
    logic             r_out_vld;
    logic             ok;
    logic [POS_W-1:0] avail;
    logic [31:0]      avail32;
    logic [31:0]      dlen;
    logic             n_valid_res;

    assign snp_adv    = r_snp_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready = !r_snp_vld || !r_out_vld || i_out_ready;
    assign in_acc     = i_in_valid && o_in_ready;

    rwhp_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (in_acc),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_snap      (snap_next)
    );

    // Snapshot of the final parser state of a file.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snp_vld <= 1'b0;
        end else if (in_acc && i_last_byte) begin
            r_snp_vld <= 1'b1;
        end else if (snp_adv) begin
            r_snp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && i_last_byte) begin
            r_snp <= snap_next;
        end
    end

    // Result fields: overall check, and data length clamped to the bytes present.
    always_comb begin
        ok      = r_snp.hdr_good && (r_snp.pos >= MIN_FILE_BYTES) && !r_snp.pos[POS_W-1];
        avail   = r_snp.pos - POS_W'(r_snp.pay_start);
        avail32 = 32'(avail);
        dlen    = (r_snp.pay_size < avail32) ? r_snp.pay_size : avail32;
        n_valid_res = ok && r_snp.fmt_found && r_snp.pay_found && (r_snp.rate != 32'd0) &&
                      !r_snp.rate[31] && (r_snp.chan != 16'd0);
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (snp_adv) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (snp_adv) begin
            o_valid_res       <= n_valid_res;
            o_num_channels    <= ok ? r_snp.chan : 16'd0;
            o_sample_rate     <= ok ? r_snp.rate : 32'd0;
            o_bits_per_sample <= ok ? r_snp.bits : 16'd0;
            o_data_offset     <= (ok && r_snp.pay_found) ? OFS_W'(r_snp.pay_start) : '0;
            o_data_length     <= (ok && r_snp.pay_found) ? dlen[OFS_W-1:0] : '0;
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

[sv/rwhp_parse.sv]
`timescale 1ns / 1ps

module rwhp_parse (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_step,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_last_byte,
    output rwhp_pkg::t_snap      o_snap
);
    import rwhp_pkg::*;

    typedef enum logic [1:0] {PH_FILE, PH_HDR, PH_SKIP, PH_FMT} t_phase;

    t_phase                   r_phase, n_phase;
    logic [POS_W-1:0]         r_pos, n_pos;
    logic                     r_hdr_good, n_hdr_good;
    logic [31:0]              r_tag, n_tag;
    logic [31:0]              r_len, n_len;
    logic [32:0]              r_skip, n_skip;
    logic [3:0]               r_fidx, n_fidx;
    logic [15:0]              r_pend_code, n_pend_code;
    logic [15:0]              r_pend_chan, n_pend_chan;
    logic [31:0]              r_pend_rate, n_pend_rate;
    logic [7:0]               r_pend_bits_lo, n_pend_bits_lo;
    logic [15:0]              r_chan, n_chan;
    logic [31:0]              r_rate, n_rate;
    logic [15:0]              r_bits, n_bits;
    logic                     r_fmt_found, n_fmt_found;
    logic [POSITION_BITS-1:0] r_pay_start, n_pay_start;
    logic [31:0]              r_pay_size, n_pay_size;
    logic                     r_pay_found, n_pay_found;
    logic                     r_finished, n_finished;

    logic        parse_en;
    logic        do_skip;
    logic [32:0] skip_val;
    logic [31:0] len_sh;
    logic [32:0] span;
    logic [15:0] fmt_bits;
    logic        fmt_ok;

    // One byte of the walk: file header, chunk header, skip or fmt capture.
    always_comb begin
        n_phase        = r_phase;
        n_pos          = r_pos;
        n_hdr_good     = r_hdr_good;
        n_tag          = r_tag;
        n_len          = r_len;
        n_skip         = r_skip;
        n_fidx         = r_fidx;
        n_pend_code    = r_pend_code;
        n_pend_chan    = r_pend_chan;
        n_pend_rate    = r_pend_rate;
        n_pend_bits_lo = r_pend_bits_lo;
        n_chan         = r_chan;
        n_rate         = r_rate;
        n_bits         = r_bits;
        n_fmt_found    = r_fmt_found;
        n_pay_start    = r_pay_start;
        n_pay_size     = r_pay_size;
        n_pay_found    = r_pay_found;
        n_finished     = r_finished;
        parse_en       = 1'b0;
        do_skip        = 1'b0;
        fmt_ok         = 1'b0;

        len_sh   = {i_data_byte, r_len[31:8]};
        span     = {1'b0, len_sh} + {32'd0, len_sh[0]};
        fmt_bits = {i_data_byte, r_pend_bits_lo};
        skip_val = span;

        // The position saturates at the limit, and parsing stops there.
        if (r_pos >= POS_MAX) begin
            n_pos = POS_LIMIT;
        end else begin
            n_pos    = r_pos + POS_W'(1);
            parse_en = !r_finished;
        end

        if (parse_en) begin
            case (r_phase)
                PH_FILE: begin
                    if (r_pos < FILE_HDR_BYTES) begin
                        if (file_tag_care(r_pos[3:0]) &&
                            (i_data_byte != file_tag_byte(r_pos[3:0]))) begin
                            n_hdr_good = 1'b0;
                        end
                        if (r_pos[3:0] == 4'd11) begin
                            n_phase = PH_HDR;
                            n_fidx  = 4'd0;
                        end
                    end else begin
                        n_phase = PH_HDR;
                        n_fidx  = 4'd0;
                    end
                end
                PH_HDR: begin
                    // Tag and length shift in little-endian, four bytes each.
                    if (r_fidx < 4'd4) begin
                        n_tag = {i_data_byte, r_tag[31:8]};
                    end else begin
                        n_len = len_sh;
                    end
                    if (r_fidx == 4'd7) begin
                        n_fidx = 4'd0;
                        if ((r_tag == TAG_FMT) && (len_sh >= FMT_MIN_LEN)) begin
                            n_phase = PH_FMT;
                            n_skip  = span - 33'd16;
                        end else if (r_tag == TAG_DATA) begin
                            n_pay_start = r_pos[POSITION_BITS-1:0] + POSITION_BITS'(1);
                            n_pay_size  = len_sh;
                            n_pay_found = 1'b1;
                            if (r_fmt_found) begin
                                n_finished = 1'b1;
                            end else begin
                                do_skip = 1'b1;
                            end
                        end else begin
                            do_skip = 1'b1;
                        end
                    end else begin
                        n_fidx = r_fidx + 4'd1;
                    end
                end
                PH_SKIP: begin
                    if (r_skip <= 33'd1) begin
                        n_skip  = 33'd0;
                        n_phase = PH_HDR;
                        n_fidx  = 4'd0;
                    end else begin
                        n_skip = r_skip - 33'd1;
                    end
                end
                PH_FMT: begin
                    case (r_fidx)
                        4'd0:    n_pend_code[7:0]   = i_data_byte;
                        4'd1:    n_pend_code[15:8]  = i_data_byte;
                        4'd2:    n_pend_chan[7:0]   = i_data_byte;
                        4'd3:    n_pend_chan[15:8]  = i_data_byte;
                        4'd4:    n_pend_rate[7:0]   = i_data_byte;
                        4'd5:    n_pend_rate[15:8]  = i_data_byte;
                        4'd6:    n_pend_rate[23:16] = i_data_byte;
                        4'd7:    n_pend_rate[31:24] = i_data_byte;
                        4'd14:   n_pend_bits_lo     = i_data_byte;
                        default: n_pend_code        = r_pend_code;
                    endcase
                    // The sixteenth byte completes the capture.
                    if (r_fidx == 4'd15) begin
                        fmt_ok      = (r_pend_code == FMT_CODE_PCM) && (fmt_bits == PCM_BITS);
                        n_chan      = r_pend_chan;
                        n_rate      = r_pend_rate;
                        n_bits      = fmt_bits;
                        n_fmt_found = fmt_ok;
                        if (fmt_ok && r_pay_found) begin
                            n_finished = 1'b1;
                        end else begin
                            do_skip  = 1'b1;
                            skip_val = r_skip;
                        end
                    end else begin
                        n_fidx = r_fidx + 4'd1;
                    end
                end
                default: n_phase = PH_FILE;
            endcase
        end

        // Skip a payload, or go straight to the next chunk header if it is empty.
        if (do_skip) begin
            n_skip  = skip_val;
            n_phase = (skip_val != 33'd0) ? PH_SKIP : PH_HDR;
            n_fidx  = 4'd0;
        end
    end

    // State after the current byte, for the result path.
    always_comb begin
        o_snap.pos       = n_pos;
        o_snap.hdr_good  = n_hdr_good;
        o_snap.fmt_found = n_fmt_found;
        o_snap.pay_found = n_pay_found;
        o_snap.chan      = n_chan;
        o_snap.rate      = n_rate;
        o_snap.bits      = n_bits;
        o_snap.pay_start = n_pay_start;
        o_snap.pay_size  = n_pay_size;
    end

    // Parser state; the last byte of a file returns everything to reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last_byte)) begin
            r_phase     <= PH_FILE;
            r_pos       <= '0;
            r_hdr_good  <= 1'b1;
            r_tag       <= '0;
            r_len       <= '0;
            r_skip      <= '0;
            r_fidx      <= '0;
            r_chan      <= '0;
            r_rate      <= '0;
            r_bits      <= '0;
            r_fmt_found <= 1'b0;
            r_pay_start <= '0;
            r_pay_size  <= '0;
            r_pay_found <= 1'b0;
            r_finished  <= 1'b0;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_hdr_good  <= n_hdr_good;
            r_tag       <= n_tag;
            r_len       <= n_len;
            r_skip      <= n_skip;
            r_fidx      <= n_fidx;
            r_chan      <= n_chan;
            r_rate      <= n_rate;
            r_bits      <= n_bits;
            r_fmt_found <= n_fmt_found;
            r_pay_start <= n_pay_start;
            r_pay_size  <= n_pay_size;
            r_pay_found <= n_pay_found;
            r_finished  <= n_finished;
        end
    end

    // Pending fmt capture; every byte is written before it is read.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_pend_code    <= n_pend_code;
            r_pend_chan    <= n_pend_chan;
            r_pend_rate    <= n_pend_rate;
            r_pend_bits_lo <= n_pend_bits_lo;
        end
    end

endmodule

[sv/rwhp_checker.sv]
`timescale 1ns / 1ps

module rwhp_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic                       o_valid_res,
    input logic [15:0]                o_num_channels,
    input logic [31:0]                o_sample_rate,
    input logic [rwhp_pkg::OFS_W-1:0] o_data_offset,
    input logic [rwhp_pkg::OFS_W-1:0] o_data_length
);
    import rwhp_pkg::*;

    // A stalled result beat stays and keeps its result flag, sample rate, data offset and data length.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_valid_res) && $stable(o_sample_rate) &&
            $stable(o_data_offset) && $stable(o_data_length))
        else $error("result beat changed while stalled");

    // A valid result has channels and a sample rate in range.
    a_valid_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_valid_res |->
            (o_num_channels != 16'd0) && (o_sample_rate != 32'd0) && !o_sample_rate[31])
        else $error("valid result with bad format fields");

    // Without a data chunk there is no data length either.
    a_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_data_offset == '0) |-> (o_data_length == '0))
        else $error("data length without data offset");

    // Reset empties the result register.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind riff_wav_header_parser rwhp_checker u_rwhp_checker (.*);

[verif/tb_riff_wav_header_parser.sv]
`timescale 1ns / 1ps

module tb_riff_wav_header_parser;
    import rwhp_pkg::*;

    // File tags as they arrive little-endian, first byte in the low bits.
    localparam logic [31:0] RIFF_LE = 32'h4646_4952;
    localparam logic [31:0] WAVE_LE = 32'h4556_4157;
    localparam logic [31:0] LIST_LE = 32'h5453_494C;
    localparam logic [31:0] MAX_RATE = 32'h7FFF_FFFF;
    localparam int HOLD_OFF_CYCLES = 250;
    localparam int TOTAL_BEATS     = 750;
    localparam int RANDOM_FILES    = 1;

    typedef enum logic [1:0] {PH_FILE, PH_HDR, PH_SKIP, PH_FMT} t_walk_phase;

    typedef struct packed {
        logic             valid_res;
        logic [15:0]      num_channels;
        logic [31:0]      sample_rate;
        logic [15:0]      bits_per_sample;
        logic [OFS_W-1:0] data_offset;
        logic [OFS_W-1:0] data_length;
    } t_wav_info;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_in_valid = 1'b0;
    logic             o_in_ready;
    logic [7:0]       i_data_byte = 8'h00;
    logic             i_last_byte = 1'b0;
    logic             o_out_valid;
    logic             i_out_ready = 1'b0;
    logic             o_valid_res;
    logic [15:0]      o_num_channels;
    logic [31:0]      o_sample_rate;
    logic [15:0]      o_bits_per_sample;
    logic [OFS_W-1:0] o_data_offset;
    logic [OFS_W-1:0] o_data_length;

    riff_wav_header_parser i_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_last_byte       (i_last_byte),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_valid_res       (o_valid_res),
        .o_num_channels    (o_num_channels),
        .o_sample_rate     (o_sample_rate),
        .o_bits_per_sample (o_bits_per_sample),
        .o_data_offset     (o_data_offset),
        .o_data_length     (o_data_length)
    );

    always #2 i_clk = ~i_clk;

    // Shared run state.
    t_wav_info   header_reports_q[$];
    t_wav_info   oldest_report;
    logic [7:0]  file_buf[$];
    int          fail_count = 0;
    int          beats_sent = 0;
    int          hold_off_left = 0;
    bit          no_gaps = 1'b0;

    // Parser shadow state.
    logic [31:0] byte_pos;
    t_walk_phase walk_phase;
    logic        hdr_ok;
    logic [31:0] chunk_tag;
    logic [31:0] chunk_len;
    logic [32:0] skip_left;
    int          field_idx;
    logic [15:0] pend_code;
    logic [15:0] pend_chan;
    logic [31:0] pend_rate;
    logic [15:0] pend_bits;
    logic [15:0] kept_chan;
    logic [31:0] kept_rate;
    logic [15:0] kept_bits;
    logic        fmt_ok;
    logic [31:0] pay_start;
    logic [31:0] pay_size;
    logic        pay_seen;
    logic        walk_done;

    function automatic void clear_parser();
        byte_pos   = '0;
        walk_phase = PH_FILE;
        hdr_ok     = 1'b1;
        chunk_tag  = '0;
        chunk_len  = '0;
        skip_left  = '0;
        field_idx  = 0;
        pend_code  = '0;
        pend_chan  = '0;
        pend_rate  = '0;
        pend_bits  = '0;
        kept_chan  = '0;
        kept_rate  = '0;
        kept_bits  = '0;
        fmt_ok     = 1'b0;
        pay_start  = '0;
        pay_size   = '0;
        pay_seen   = 1'b0;
        walk_done  = 1'b0;
    endfunction

    function automatic void go_skip(logic [32:0] n);
        skip_left  = n;
        walk_phase = (n != 0) ? PH_SKIP : PH_HDR;
        field_idx  = 0;
    endfunction

    // A chunk header is complete: decide between fmt capture, data record and skip.
    function automatic void chunk_header_done(logic [31:0] pos);
        logic [32:0] span;
        span = {1'b0, chunk_len} + chunk_len[0];
        if (chunk_tag == TAG_FMT && chunk_len >= FMT_MIN_LEN) begin
            walk_phase = PH_FMT;
            field_idx  = 0;
            pend_code  = '0;
            pend_chan  = '0;
            pend_rate  = '0;
            pend_bits  = '0;
            skip_left  = span - 33'd16;
        end else if (chunk_tag == TAG_DATA) begin
            pay_start = pos + 32'd1;
            pay_size  = chunk_len;
            pay_seen  = 1'b1;
            if (fmt_ok) walk_done = 1'b1;
            else go_skip(span);
        end else begin
            go_skip(span);
        end
    endfunction

    function automatic void fmt_payload_byte(logic [7:0] b);
        int k;
        k = field_idx;
        if (k < 2) pend_code[8*k +: 8] = b;
        else if (k < 4) pend_chan[8*(k-2) +: 8] = b;
        else if (k < 8) pend_rate[8*(k-4) +: 8] = b;
        else if (k >= 14 && k < 16) pend_bits[8*(k-14) +: 8] = b;
        field_idx = k + 1;
        if (field_idx >= 16) begin
            kept_chan = pend_chan;
            kept_rate = pend_rate;
            kept_bits = pend_bits;
            fmt_ok = (pend_code == FMT_CODE_PCM) && (pend_bits == PCM_BITS);
            if (fmt_ok && pay_seen) walk_done = 1'b1;
            else go_skip(skip_left);
        end
    endfunction

    function automatic void walk_byte(logic [31:0] pos, logic [7:0] b);
        int idx;
        idx = pos;
        case (walk_phase)
            PH_FILE: begin
                if (pos < FILE_HDR_BYTES) begin
                    if (idx < 4 && b != RIFF_LE[8*idx +: 8]) hdr_ok = 1'b0;
                    if (idx >= 8 && b != WAVE_LE[8*(idx-8) +: 8]) hdr_ok = 1'b0;
                    if (idx == 11) begin
                        walk_phase = PH_HDR;
                        field_idx  = 0;
                    end
                end else begin
                    walk_phase = PH_HDR;
                    field_idx  = 0;
                end
            end
            PH_HDR: begin
                if (field_idx == 0) begin
                    chunk_tag = '0;
                    chunk_len = '0;
                end
                if (field_idx < 4) chunk_tag[8*field_idx +: 8] = b;
                else if (field_idx < 8) chunk_len[8*(field_idx-4) +: 8] = b;
                field_idx++;
                if (field_idx >= 8) begin
                    field_idx = 0;
                    chunk_header_done(pos);
                end
            end
            PH_SKIP: begin
                if (skip_left != 0) skip_left--;
                if (skip_left == 0) begin
                    walk_phase = PH_HDR;
                    field_idx  = 0;
                end
            end
            default: fmt_payload_byte(b);
        endcase
    endfunction

    // Advance the shadow parser by one accepted byte; a last byte yields the header report.
    function automatic void predict_header_byte(logic [7:0] b, logic last);
        logic [31:0] pos;
        logic [31:0] n;
        logic [31:0] avail;
        logic [31:0] len;
        t_wav_info   rep;
        pos = byte_pos;
        if (pos >= POS_LIMIT - 1) begin
            byte_pos = POS_LIMIT;
        end else begin
            byte_pos = pos + 32'd1;
            if (!walk_done) walk_byte(pos, b);
        end
        if (last) begin
            n   = byte_pos;
            rep = '0;
            if (hdr_ok && n >= MIN_FILE_BYTES && n < POS_LIMIT) begin
                rep.num_channels    = kept_chan;
                rep.sample_rate     = kept_rate;
                rep.bits_per_sample = kept_bits;
                if (pay_seen) begin
                    avail = n - pay_start;
                    len   = (pay_size < avail) ? pay_size : avail;
                    rep.data_offset = pay_start[OFS_W-1:0];
                    rep.data_length = len[OFS_W-1:0];
                end
                rep.valid_res = fmt_ok && pay_seen && kept_rate > 0 &&
                                kept_rate <= MAX_RATE && kept_chan > 0;
            end
            header_reports_q.push_back(rep);
            clear_parser();
        end
    endfunction

    function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    // Result side: check each accepted beat against the oldest report, then pick next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (header_reports_q.size() == 0) begin
                $error("result beat with no report outstanding");
                fail_count++;
            end else begin
                oldest_report = header_reports_q.pop_front();
                cmp_field("valid_res", 32'(oldest_report.valid_res), 32'(o_valid_res));
                cmp_field("num_channels", 32'(oldest_report.num_channels),
                          32'(o_num_channels));
                cmp_field("sample_rate", oldest_report.sample_rate, o_sample_rate);
                cmp_field("bits_per_sample", 32'(oldest_report.bits_per_sample),
                          32'(o_bits_per_sample));
                cmp_field("data_offset", 32'(oldest_report.data_offset),
                          32'(o_data_offset));
                cmp_field("data_length", 32'(oldest_report.data_length),
                          32'(o_data_length));
            end
        end
        if (hold_off_left > 0) begin
            hold_off_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= no_gaps || ($urandom_range(99) >= 30);
        end
    end

    // Input side: one byte beat, with random idle cycles in front of it unless no_gaps is set.
    task automatic send_beat(input logic [7:0] b, input logic last);
        while (!no_gaps && $urandom_range(99) < 30) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_header_byte(b, last);
        beats_sent++;
    endtask

    task automatic send_file();
        for (int i = 0; i < file_buf.size(); i++)
            send_beat(file_buf[i], i == file_buf.size() - 1);
        file_buf.delete();
    endtask

    task automatic wait_reports_drained();
        i_in_valid <= 1'b0;
        while (header_reports_q.size() != 0) @(posedge i_clk);
    endtask

    // File builders append to file_buf.
    function automatic void put_le(logic [31:0] v, int nbytes);
        for (int i = 0; i < nbytes; i++) file_buf.push_back(v[8*i +: 8]);
    endfunction

    function automatic void put_noise(int n);
        for (int i = 0; i < n; i++) file_buf.push_back(8'($urandom_range(255)));
    endfunction

    function automatic void put_file_header();
        put_le(RIFF_LE, 4);
        put_le($urandom, 4);
        put_le(WAVE_LE, 4);
    endfunction

    function automatic void put_chunk_head(logic [31:0] tag, logic [31:0] len);
        put_le(tag, 4);
        put_le(len, 4);
    endfunction

    // A fmt chunk with its 16 fixed bytes if it is long enough, any extension bytes and the pad byte.
    function automatic void put_fmt(int len, logic [15:0] code, logic [15:0] chan,
                                    logic [31:0] rate, logic [15:0] bits);
        put_chunk_head(TAG_FMT, len);
        if (len >= 16) begin
            put_le(32'(code), 2);
            put_le(32'(chan), 2);
            put_le(rate, 4);
            put_noise(6);
            put_le(32'(bits), 2);
            put_noise(len - 16 + (len % 2));
        end else begin
            put_noise(len + (len % 2));
        end
    endfunction

    function automatic void put_pcm16(logic [15:0] chan, logic [31:0] rate);
        put_fmt(16, FMT_CODE_PCM, chan, rate, PCM_BITS);
    endfunction

    function automatic void put_data(logic [31:0] len, int present);
        put_chunk_head(TAG_DATA, len);
        put_noise(present);
    endfunction

    function automatic void put_minimal_file();
        put_file_header();
        put_pcm16(16'd2, 32'd44100);
        put_data(32'd8, 8);
    endfunction

    function automatic void put_random_fmt();
        int          len;
        int          pick;
        logic [15:0] code;
        logic [15:0] bits;
        logic [15:0] chan;
        logic [31:0] rate;
        pick = $urandom_range(99);
        if (pick < 60) len = 16;
        else if (pick < 90) len = $urandom_range(20, 17);
        else len = $urandom_range(15);
        code = ($urandom_range(9) == 0) ? 16'($urandom) : FMT_CODE_PCM;
        bits = ($urandom_range(99) < 15) ? 16'($urandom) : PCM_BITS;
        pick = $urandom_range(9);
        if (pick == 0) chan = 16'd0;
        else if (pick == 1) chan = 16'($urandom);
        else chan = 16'($urandom_range(8, 1));
        rate = ($urandom_range(4) == 0) ? $urandom : $urandom_range(192000, 8000);
        put_fmt(len, code, chan, rate, bits);
    endfunction

    // A well-formed file with random content, broken now and then.
    function automatic void build_random_file();
        int  len;
        int  cut;
        bit  data_first;
        if ($urandom_range(99) < 8) begin
            put_noise($urandom_range(70, 1));
            return;
        end
        put_file_header();
        if ($urandom_range(3) == 0) begin
            len = $urandom_range(9);
            put_chunk_head($urandom, len);
            put_noise(len + len % 2);
        end
        data_first = ($urandom_range(4) == 0);
        if (data_first) begin
            len = $urandom_range(12);
            put_data(len, len + len % 2);
        end
        put_random_fmt();
        if ($urandom_range(4) == 0) begin
            len = $urandom_range(7);
            put_chunk_head(LIST_LE, len);
            put_noise(len + len % 2);
        end
        if (!data_first) begin
            len = $urandom_range(12);
            put_data(len, ($urandom_range(3) == 0) ? $urandom_range(len + 4) : len);
        end
        if ($urandom_range(99) < 10) begin
            cut = $urandom_range(11);
            if (cut < 4 || cut > 7) file_buf[cut] = file_buf[cut] ^ (8'h01 << $urandom_range(7));
        end
        if ($urandom_range(99) < 15) begin
            cut = $urandom_range(file_buf.size(), 1);
            while (file_buf.size() > cut) void'(file_buf.pop_back());
        end
    endfunction

    // Test: a plain PCM16 file.
    task automatic test_minimal_file();
        put_minimal_file();
        send_file();
    endtask

    // Test: a corrupted bit in one checked byte of the RIFF tag and one of the WAVE tag.
    task automatic test_bad_header();
        int p;
        for (int k = 0; k < 2; k++) begin
            p = (k == 0) ? int'($urandom_range(3)) : int'($urandom_range(11, 8));
            put_minimal_file();
            file_buf[p] = file_buf[p] ^ (8'h01 << $urandom_range(7));
            send_file();
        end
    endtask

    // Test: a single-byte file, one byte short of the minimum, and exactly the minimum.
    task automatic test_short_streams();
        put_noise(1);
        send_file();
        put_file_header();
        put_pcm16(16'd1, 32'd8000);
        put_chunk_head(TAG_DATA, 32'd0);
        void'(file_buf.pop_back());
        send_file();
        put_file_header();
        put_pcm16(16'd1, 32'd8000);
        put_data(32'd0, 0);
        send_file();
    endtask

    // Test: fmt chunks with odd length, non-PCM code, other sample sizes, too short.
    task automatic test_fmt_variants();
        put_file_header();
        put_fmt(17, FMT_CODE_PCM, 16'd2, 32'd48000, PCM_BITS);
        put_data(32'd4, 4);
        send_file();
        put_file_header();
        put_fmt(16, 16'd3, 16'd2, 32'd48000, PCM_BITS);
        put_data(32'd4, 4);
        send_file();
        put_file_header();
        put_fmt(18, FMT_CODE_PCM, 16'd6, 32'd96000, 16'd24);
        put_data(32'd4, 4);
        send_file();
        put_file_header();
        put_fmt(12, FMT_CODE_PCM, 16'd2, 32'd22050, PCM_BITS);
        put_data(32'd6, 6);
        send_file();
    endtask

    // Test: chunk order, replacement by later chunks, clamping, bytes after the walk ends.
    task automatic test_chunk_order();
        put_file_header();
        put_chunk_head(LIST_LE, 32'd5);
        put_noise(6);
        put_pcm16(16'd2, 32'd32000);
        put_data(32'd100, 3);
        send_file();
        put_file_header();
        put_data(32'd3, 4);
        put_data(32'd5, 6);
        put_pcm16(16'd1, 32'd11025);
        put_noise(9);
        send_file();
        put_file_header();
        put_pcm16(16'd2, 32'd44100);
        put_fmt(16, FMT_CODE_PCM, 16'd4, 32'd8000, PCM_BITS);
        put_fmt(16, 16'hFFFE, 16'd3, 32'd16000, PCM_BITS);
        put_data(32'd2, 2);
        put_pcm16(16'd5, 32'd12000);
        put_noise(3);
        send_file();
    endtask

    // Test: a chunk header cut off at the end, and a fmt capture cut off at the end.
    task automatic test_cut_off_chunks();
        put_file_header();
        put_pcm16(16'd2, 32'd44100);
        put_chunk_head(LIST_LE, 32'd10);
        put_noise(10);
        put_le(TAG_DATA, 4);
        put_noise(1);
        send_file();
        put_file_header();
        put_data(32'd4, 4);
        put_chunk_head(LIST_LE, 32'd10);
        put_noise(10);
        put_chunk_head(TAG_FMT, 32'd16);
        put_le(32'(FMT_CODE_PCM), 2);
        put_noise(5);
        send_file();
    endtask

    // Test: extreme sample rates and channel counts.
    task automatic test_field_extremes();
        logic [31:0] rate_pick;
        logic [15:0] chan_pick;
        for (int i = 0; i < 4; i++) begin
            case (i)
                0: begin
                    rate_pick = 32'd0;
                    chan_pick = 16'd1;
                end
                1: begin
                    rate_pick = MAX_RATE;
                    chan_pick = 16'hFFFF;
                end
                2: begin
                    rate_pick = 32'h8000_0000;
                    chan_pick = 16'd1;
                end
                default: begin
                    rate_pick = 32'd1;
                    chan_pick = 16'd0;
                end
            endcase
            put_file_header();
            put_fmt(16, FMT_CODE_PCM, chan_pick, rate_pick, PCM_BITS);
            put_data(32'd2, 2);
            send_file();
        end
    endtask

    // Test: chunk lengths at the top of the 32-bit range.
    task automatic test_huge_lengths();
        put_file_header();
        put_chunk_head(LIST_LE, 32'hFFFF_FFFF);
        put_noise(4);
        send_file();
        put_file_header();
        put_fmt(16, FMT_CODE_PCM, 16'd2, 32'd44100, PCM_BITS);
        file_buf[16] = 8'hFF;
        file_buf[17] = 8'hFF;
        file_buf[18] = 8'hFF;
        file_buf[19] = 8'hFF;
        put_noise(8);
        send_file();
        put_file_header();
        put_pcm16(16'd2, 32'd44100);
        put_data(32'hFFFF_FFFF, 5);
        send_file();
        put_file_header();
        put_pcm16(16'd1, 32'd8000);
        put_data(32'h8000_0000, 7);
        send_file();
    endtask

    // Test: results held back long enough that the block stalls its input, then a drain.
    task automatic test_back_pressure();
        wait_reports_drained();
        hold_off_left = HOLD_OFF_CYCLES;
        for (int i = 0; i < 5; i++) begin
            put_noise($urandom_range(3, 1));
            send_file();
        end
        put_minimal_file();
        send_file();
        wait_reports_drained();
    endtask

    // Test: both sides running without idle cycles.
    task automatic test_no_gaps();
        no_gaps = 1'b1;
        for (int i = 0; i < 2; i++) begin
            build_random_file();
            send_file();
        end
        put_noise(1);
        send_file();
        put_noise(1);
        send_file();
        no_gaps = 1'b0;
    endtask

    // Test: random files until the run has sent enough beats.
    task automatic test_random_files();
        int files;
        files = 0;
        while (beats_sent < TOTAL_BEATS || files < RANDOM_FILES) begin
            build_random_file();
            send_file();
            files++;
        end
    endtask

    initial begin
        clear_parser();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_minimal_file();
        test_bad_header();
        test_short_streams();
        test_fmt_variants();
        test_chunk_order();
        test_cut_off_chunks();
        test_field_extremes();
        test_huge_lengths();
        test_back_pressure();
        test_no_gaps();
        test_random_files();
        // Let the last results come out, then keep the clock running for stray beats.
        wait_reports_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
